/* sv/slt_pkg.sv */
`timescale 1ns / 1ps

package slt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } slt_op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_BAD_POSITION = 2'd2,
    ST_FULL         = 2'd3
  } slt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_FIN,
    S_REM,
    S_RD
  } slt_state_e;

  typedef struct packed {
    slt_op_e     opcode;
    logic [31:0] value;
    logic [7:0]  position;
  } slt_cmd_t;

  typedef struct packed {
    slt_status_e status;
    logic [31:0] read_value;
    logic [6:0]  entry_count;
  } slt_result_t;

endpackage

/* sv/slt_store.sv */
`timescale 1ns / 1ps

module slt_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sorted_list_table_top.sv */
`timescale 1ns / 1ps
// Rejects answer in the next cycle; reads answer after the registered store read.
// Throughput: one item at a time, bound by the walk over the store,
// one entry per cycle.
// Result strobe is high for one cycle; the receiver cannot stall.
// Reset (async, active low) empties the table; no clearing pass is needed.
module sorted_list_table_top #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  slt_pkg::slt_cmd_t    cmd_i,
  output logic                result_valid_o,
  output slt_pkg::slt_result_t result_o
);
  import slt_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  slt_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic found_q, found_d;
  logic res_valid_q, res_valid_d;
  slt_result_t res_q, res_d;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

  logic [VALUE_WIDTH-1:0] v_in;
  logic [CW-1:0] idx_m1, idx_m2, idx_p1, cnt_m1, cnt_p1;
  logic accept, is_full, is_empty, pos_ok, ins_shift, ins_last, rem_last, hit;

  assign v_in      = VALUE_WIDTH'(cmd_i.value);
  assign idx_m1    = idx_q - CW'(1);
  assign idx_m2    = idx_q - CW'(2);
  assign idx_p1    = idx_q + CW'(1);
  assign cnt_m1    = count_q - CW'(1);
  assign cnt_p1    = count_q + CW'(1);
  assign accept    = start && (state_q == S_IDLE);
  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign pos_ok    = (CMPW'(cmd_i.position) < CMPW'(count_q));
  assign ins_shift = (mem_rdata >= v_q);
  assign ins_last  = (idx_q == CW'(1));
  assign rem_last  = (idx_q == cnt_m1);
  assign hit       = (mem_rdata == v_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.opcode)
            OP_INSERT: if (!is_full && !is_empty) state_d = S_INS;
            OP_REMOVE: if (!is_empty) state_d = S_REM;
            OP_READ:   if (pos_ok) state_d = S_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (!ins_shift) state_d = S_IDLE;
        else if (ins_last) state_d = S_INS_FIN;
      end
      S_INS_FIN: state_d = S_IDLE;
      S_REM:     if (rem_last) state_d = S_IDLE;
      S_RD:      state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    v_d         = v_q;
    found_d     = found_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = v_q;
    mem_raddr   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          v_d     = v_in;
          found_d = 1'b0;
          res_d.read_value = '0;
          case (cmd_i.opcode)
            OP_INSERT: begin
              if (is_full) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_FULL;
              end else if (is_empty) begin
                mem_we       = 1'b1;
                mem_waddr    = '0;
                mem_wdata    = v_in;
                count_d      = cnt_p1;
                res_valid_d  = 1'b1;
                res_d.status = ST_OK;
              end else begin
                mem_raddr = cnt_m1[AW-1:0];
                idx_d     = count_q;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_NOT_FOUND;
              end else begin
                mem_raddr = '0;
                idx_d     = '0;
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                mem_raddr = AW'(cmd_i.position);
              end else begin
                res_valid_d  = 1'b1;
                res_d.status = ST_BAD_POSITION;
              end
            end
            default: begin
              res_valid_d  = 1'b1;
              res_d.status = ST_BAD_POSITION;
            end
          endcase
        end
      end
      S_INS: begin
        mem_we = 1'b1;
        if (ins_shift) begin
          mem_wdata = mem_rdata;
          idx_d     = idx_m1;
          mem_raddr = idx_m2[AW-1:0];
        end else begin
          count_d          = cnt_p1;
          res_valid_d      = 1'b1;
          res_d.status     = ST_OK;
          res_d.read_value = '0;
        end
      end
      S_INS_FIN: begin
        mem_we           = 1'b1;
        count_d          = cnt_p1;
        res_valid_d      = 1'b1;
        res_d.status     = ST_OK;
        res_d.read_value = '0;
      end
      S_REM: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = idx_m1[AW-1:0];
          mem_wdata = mem_rdata;
        end else if (hit) begin
          found_d = 1'b1;
        end
        if (rem_last) begin
          res_valid_d      = 1'b1;
          res_d.read_value = '0;
          if (found_q || hit) begin
            count_d      = cnt_m1;
            res_d.status = ST_OK;
          end else begin
            res_d.status = ST_NOT_FOUND;
          end
        end else begin
          mem_raddr = idx_p1[AW-1:0];
          idx_d     = idx_p1;
        end
      end
      S_RD: begin
        res_valid_d      = 1'b1;
        res_d.status     = ST_OK;
        res_d.read_value = 32'(mem_rdata);
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
    res_d.entry_count = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    v_q   <= v_d;
    res_q <= res_d;
  end

  slt_store #(
    .DEPTH(CAPACITY),
    .WIDTH(VALUE_WIDTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

/* sv/slt_checker.sv */
`timescale 1ns / 1ps

module slt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input slt_pkg::slt_cmd_t    cmd_i,
  input logic                 result_valid_o,
  input slt_pkg::slt_result_t result_o
);
  import slt_pkg::*;

  a_none_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.opcode == OP_NONE
    |=> result_valid_o && result_o.status == ST_BAD_POSITION)
    else $error("no-op item did not give a bad position result");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ST_OK |-> result_o.read_value == '0)
    else $error("failed item carries a nonzero read value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == ST_FULL
    |-> result_o.entry_count == 7'(CAPACITY))
    else $error("full reported below capacity");

  a_busy_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy raised without an accepted item");

endmodule

bind sorted_list_table_top slt_checker #(.CAPACITY(CAPACITY)) u_slt_checker (.*);
